@@ rtl/plcl_pkg.sv @@
`timescale 1ns / 1ps

package plcl_pkg;

  localparam int MAX_POINTS  = 4;
  localparam int PT_SLOTS    = 4;
  localparam int PT_IDX_W    = $clog2(PT_SLOTS);
  localparam int CNT_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int XY_W        = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = XY_W;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_0     = 3'd1;

  typedef struct packed {
    logic [CNT_W-1:0]                    count;
    logic [PT_SLOTS-1:0][CFG_DATA_W-1:0] pt;
  } plcl_cfg_t;

  // one classified query on its way to the back end
  typedef struct packed {
    logic                   bypass;
    logic signed [XY_W-1:0] byp_y;
    logic signed [XY_W-1:0] y0;
    logic [XY_W-1:0]        dx;
    logic [XY_W-1:0]        t;
    logic signed [XY_W:0]   dy;
  } plcl_item_t;

endpackage

@@ rtl/plcl_front.sv @@
`timescale 1ns / 1ps

module plcl_front import plcl_pkg::*; (
  input  logic                   start,
  input  logic signed [XY_W-1:0] in_query_x,
  input  plcl_cfg_t              cfg,
  input  logic                   q_full,
  output logic                   busy,
  output logic                   push,
  output plcl_item_t             item
);

  logic [CNT_W-1:0]       n;
  logic [PT_IDX_W-1:0]    lst;
  logic signed [XY_W-1:0] xs [PT_SLOTS];
  logic signed [XY_W-1:0] ys [PT_SLOTS];

  assign busy = q_full;
  assign push = start && !q_full;

  assign n   = (cfg.count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cfg.count;
  assign lst = PT_IDX_W'(n - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < PT_SLOTS; i++) begin
      xs[i] = $signed(cfg.pt[i][CFG_DATA_W-1:XY_W]);
      ys[i] = $signed(cfg.pt[i][XY_W-1:0]);
    end
  end

  always_comb begin
    logic                 found;
    logic signed [XY_W:0] dxw;
    logic signed [XY_W:0] tw;
    item  = '0;
    found = 1'b0;
    dxw   = '0;
    tw    = '0;
    if (n == '0) begin
      item.bypass = 1'b1;
      item.byp_y  = '0;
    end else if (in_query_x <= xs[0]) begin
      item.bypass = 1'b1;
      item.byp_y  = ys[0];
    end else if (in_query_x >= xs[lst]) begin
      item.bypass = 1'b1;
      item.byp_y  = ys[lst];
    end else begin
      // no segment holds x: pass the query through
      item.bypass = 1'b1;
      item.byp_y  = in_query_x;
      for (int i = 0; i < PT_SLOTS - 1; i++) begin
        if (!found && (i + 1 < int'(n)) && in_query_x >= xs[i] && in_query_x <= xs[i+1]) begin
          found = 1'b1;
          dxw   = $signed({xs[i+1][XY_W-1], xs[i+1]}) - $signed({xs[i][XY_W-1], xs[i]});
          tw    = $signed({in_query_x[XY_W-1], in_query_x}) - $signed({xs[i][XY_W-1], xs[i]});
          if (dxw == '0) begin
            item.byp_y = ys[i];
          end else begin
            item.bypass = 1'b0;
            item.y0     = ys[i];
            item.dx     = dxw[XY_W-1:0];
            item.t      = tw[XY_W-1:0];
            item.dy     = $signed({ys[i+1][XY_W-1], ys[i+1]}) - $signed({ys[i][XY_W-1], ys[i]});
          end
        end
      end
    end
  end

endmodule

@@ rtl/plcl_queue.sv @@
`timescale 1ns / 1ps

module plcl_queue import plcl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  plcl_item_t push_item,
  input  logic       pop,
  output logic       not_empty,
  output logic       full,
  output plcl_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  plcl_item_t        ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_QW'(QUEUE_DEPTH));
  assign pop_item  = ent_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_QW'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/plcl_back.sv @@
`timescale 1ns / 1ps

module plcl_back import plcl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  plcl_item_t             q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  output logic signed [XY_W-1:0] out_curve_y
);

  typedef struct packed {
    logic                   byp;
    logic signed [XY_W-1:0] byp_y;
    logic                   neg;
    logic [XY_W-1:0]        dx;
    logic [XY_W-1:0]        rem;
    logic [XY_W-1:0]        low;
    logic [XY_W-1:0]        quo;
  } div_stage_t;

  localparam int P1_W  = 2 * XY_W + 1;
  localparam int P2_W  = 2 * XY_W + 2;
  localparam int NUM_W = 2 * XY_W + 3;

  // product stage
  logic                   mul_vld_r;
  logic                   mul_byp_r;
  logic signed [XY_W-1:0] mul_byp_y_r;
  logic [XY_W-1:0]        mul_dx_r;
  logic signed [P1_W-1:0] mul_p1_r, mul_p1_nxt;
  logic signed [P2_W-1:0] mul_p2_r, mul_p2_nxt;

  // sum stage feeds stage 0 of the divider
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;

  logic       stg_vld_r [DIV_STEPS+1];
  div_stage_t stg_r     [DIV_STEPS+1];
  div_stage_t stg_nxt   [DIV_STEPS+1];

  logic signed [XY_W-1:0] out_y_r, out_y_nxt;
  logic                   out_vld_r;

  // the back end never stalls: take a queued item every cycle one is there
  assign q_pop = q_valid;

  assign mul_p1_nxt = q_item.y0 * $signed({1'b0, q_item.dx});
  assign mul_p2_nxt = $signed({1'b0, q_item.t}) * q_item.dy;

  always_ff @(posedge clk) begin
    mul_byp_r   <= q_item.bypass;
    mul_byp_y_r <= q_item.byp_y;
    mul_dx_r    <= q_item.dx;
    mul_p1_r    <= mul_p1_nxt;
    mul_p2_r    <= mul_p2_nxt;
  end

  assign num = NUM_W'(mul_p1_r) + NUM_W'(mul_p2_r);
  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_comb begin
    logic [XY_W:0] r2;
    logic [XY_W:0] diff;
    logic          ge;
    r2   = '0;
    diff = '0;
    ge   = 1'b0;
    stg_nxt[0].byp   = mul_byp_r;
    stg_nxt[0].byp_y = mul_byp_y_r;
    stg_nxt[0].neg   = num[NUM_W-1];
    stg_nxt[0].dx    = mul_dx_r;
    // the quotient fits 16 bits, so the high part is already below the divisor
    stg_nxt[0].rem   = mag[2*XY_W-1:XY_W];
    stg_nxt[0].low   = mag[XY_W-1:0];
    stg_nxt[0].quo   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r2   = {stg_r[k].rem, stg_r[k].low[XY_W-1]};
      diff = r2 - {1'b0, stg_r[k].dx};
      ge   = (r2 >= {1'b0, stg_r[k].dx});
      stg_nxt[k+1]     = stg_r[k];
      stg_nxt[k+1].rem = ge ? diff[XY_W-1:0] : r2[XY_W-1:0];
      stg_nxt[k+1].low = {stg_r[k].low[XY_W-2:0], 1'b0};
      stg_nxt[k+1].quo = {stg_r[k].quo[XY_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STEPS; k++) begin
      stg_r[k] <= stg_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        stg_vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else begin
      mul_vld_r    <= q_valid;
      stg_vld_r[0] <= mul_vld_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        stg_vld_r[k+1] <= stg_vld_r[k];
      end
      out_vld_r <= stg_vld_r[DIV_STEPS];
    end
  end

  always_comb begin
    if (stg_r[DIV_STEPS].byp) begin
      out_y_nxt = stg_r[DIV_STEPS].byp_y;
    end else if (stg_r[DIV_STEPS].neg) begin
      out_y_nxt = $signed(XY_W'(-stg_r[DIV_STEPS].quo));
    end else begin
      out_y_nxt = $signed(stg_r[DIV_STEPS].quo);
    end
  end

  always_ff @(posedge clk) begin
    out_y_r <= out_y_nxt;
  end

  assign out_valid   = out_vld_r;
  assign out_curve_y = out_y_r;

endmodule

@@ rtl/piecewise_linear_curve_lookup.sv @@
`timescale 1ns / 1ps

// Piecewise-linear curve lookup over up to four breakpoints. Load the
// breakpoints and point_count through the write port while no query is in
// flight; each query_x transferred on start (while busy is low) yields one
// curve_y on out_valid, a single-cycle strobe that the receiver must take
// because it cannot stall the block. A new query is taken every cycle; each
// result follows its transfer in order, through the queue, product and sum
// registers, the 16-stage radix-2 divider pipeline in the back end and the
// output register. busy rises only if the queue between the classifier and
// the back end fills, which cannot happen while the back end drains one item
// per cycle.
module piecewise_linear_curve_lookup import plcl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [XY_W-1:0] in_query_x,
  output logic                   out_valid,
  output logic signed [XY_W-1:0] out_curve_y,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LATENCY = 20;

  logic [CNT_W-1:0]      count_r;
  logic [CFG_DATA_W-1:0] pt_r [PT_SLOTS];
  logic [CFG_IDX_W-1:0]  pt_off;
  plcl_cfg_t             cfg;

  logic       push;
  plcl_item_t push_item;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  plcl_item_t q_item;

  // configuration registers; writes to unknown indexes drop
  assign pt_off = cfg_index - REG_POINT_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < PT_SLOTS; i++) begin
        pt_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_POINT_COUNT) begin
        count_r <= cfg_wdata[CNT_W-1:0];
      end else if (int'(cfg_index) >= int'(REG_POINT_0) &&
                   int'(cfg_index) < int'(REG_POINT_0) + PT_SLOTS) begin
        pt_r[pt_off[PT_IDX_W-1:0]] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    cfg.count = count_r;
    for (int i = 0; i < PT_SLOTS; i++) begin
      cfg.pt[i] = pt_r[i];
    end
  end

  // front end: accept and classify the query against the breakpoints
  plcl_front u_front (
    .start      (start),
    .in_query_x (in_query_x),
    .cfg        (cfg),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .item       (push_item)
  );

  // hold classified items between the two halves
  plcl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .not_empty (q_valid),
    .full      (q_full),
    .pop_item  (q_item)
  );

  // back end: products, signed sum, pipelined divide by the segment width
  plcl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_curve_y (out_curve_y)
  );

  // every transfer in gives a strobe out at the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result strobe missing after query transfer");

  // no strobe without a query transfer at the fixed latency before it
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without matching query");

  // the back end drains one item per cycle, so the queue never fills
  a_no_full: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue filled although back end never stalls");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import plcl_pkg::*;

  // First register index past the breakpoint slots; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(int'(REG_POINT_0) + PT_SLOTS);
  localparam int SPARE_SLOTS = (1 << CFG_IDX_W) - PT_SLOTS - 1;
  localparam int IDLE_PCT    = 29;
  localparam int DRAIN_WAIT  = 40;   // well past the pipeline latency
  localparam int MAX_SHOWN   = 10;

  // Curve mirror plus the in-order queue of expected ordinates
  class curve_scoreboard;
    logic [CNT_W-1:0]      count;
    logic [CFG_DATA_W-1:0] pts[PT_SLOTS];
    logic signed [XY_W-1:0] pending_y[$];
    int mismatches;

    function new();
      count = '0;
      foreach (pts[i]) pts[i] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic [CFG_IDX_W-1:0] off;
      off = idx - REG_POINT_0;
      if (idx == REG_POINT_COUNT) begin
        count = data[CNT_W-1:0];
      end else if (idx >= REG_POINT_0 && idx < REG_SPARE_FIRST) begin
        pts[off[PT_IDX_W-1:0]] = data;
      end
    endfunction

    function longint knot_x(int i);
      return longint'($signed(pts[i][31:16]));
    endfunction

    function longint knot_y(int i);
      return longint'($signed(pts[i][15:0]));
    endfunction

    // Clamp at both ends, else interpolate on the first segment that holds x;
    // the whole sum is truncated toward zero, not y0 plus a truncated quotient.
    function logic signed [XY_W-1:0] curve_eval(logic signed [XY_W-1:0] x);
      int n;
      longint xq, x0, x1, dx, dy, num;
      n = (int'(count) > MAX_POINTS) ? MAX_POINTS : int'(count);
      if (n == 0) return '0;
      xq = x;
      if (xq <= knot_x(0)) return XY_W'(knot_y(0));
      if (xq >= knot_x(n - 1)) return XY_W'(knot_y(n - 1));
      for (int i = 0; i + 1 < n; i++) begin
        x0 = knot_x(i);
        x1 = knot_x(i + 1);
        if (xq >= x0 && xq <= x1) begin
          dx = x1 - x0;
          dy = knot_y(i + 1) - knot_y(i);
          if (dx == 0) return XY_W'(knot_y(i));
          num = knot_y(i) * dx + (xq - x0) * dy;
          return XY_W'(num / dx);
        end
      end
      return x;
    endfunction

    function void note_query(logic signed [XY_W-1:0] x);
      pending_y.push_back(curve_eval(x));
    endfunction

    function void check_result(logic signed [XY_W-1:0] y);
      logic signed [XY_W-1:0] want;
      if (pending_y.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected curve_y %0d with no query outstanding", y);
        return;
      end
      want = pending_y.pop_front();
      if (y !== want) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("curve_y mismatch: expected %0d, got %0d", want, y);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [XY_W-1:0] in_query_x = '0;
  logic                   out_valid;
  logic signed [XY_W-1:0] out_curve_y;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  curve_scoreboard sb;

  // Current curve as seen by the query picker
  int knot_xs[PT_SLOTS];
  int used_n;
  int span_lo, span_hi;
  int idle_pct;

  // Queries for the full-swing curve: both ends, around each breakpoint
  logic signed [XY_W-1:0] r_list[11] = '{-16'sd32768, -16'sd32767, -16'sd101,
                                          -16'sd100, 16'sd0, 16'sd1, -16'sd1,
                                          16'sd99, 16'sd100, 16'sd32766, 16'sd32767};

  piecewise_linear_curve_lookup dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_query_x  (in_query_x),
    .out_valid   (out_valid),
    .out_curve_y (out_curve_y),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample both channels at the edge: a query transfers when start is high and
  // busy low; a result is a one-cycle strobe and must be taken on that edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_query(in_query_x);
      if (out_valid) sb.check_result(out_curve_y);
    end
  end

  function automatic logic [CFG_DATA_W-1:0] knot_word(int x, int y);
    return {x[15:0], y[15:0]};
  endfunction

  // Write one register; keep cfg_we high across back-to-back writes
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Load count and all four breakpoints, then note which x values are in use
  task automatic load_curve(logic [CNT_W-1:0] cnt, logic [CFG_DATA_W-1:0] w0,
                            logic [CFG_DATA_W-1:0] w1, logic [CFG_DATA_W-1:0] w2,
                            logic [CFG_DATA_W-1:0] w3, bit poke_spare);
    logic [CFG_DATA_W-1:0] w[PT_SLOTS];
    w = '{w0, w1, w2, w3};
    cfg_write(REG_POINT_COUNT, CFG_DATA_W'(cnt));
    for (int i = 0; i < PT_SLOTS; i++)
      cfg_write(CFG_IDX_W'(int'(REG_POINT_0) + i), w[i]);
    // Poke a nonexistent register; the curve must not change
    if (poke_spare)
      cfg_write(CFG_IDX_W'(int'(REG_SPARE_FIRST) + int'($urandom_range(SPARE_SLOTS - 1))),
                $urandom);
    cfg_we <= 1'b0;
    used_n = (int'(cnt) > MAX_POINTS) ? MAX_POINTS : int'(cnt);
    span_lo = 0;
    span_hi = 0;
    for (int i = 0; i < PT_SLOTS; i++) knot_xs[i] = $signed(w[i][31:16]);
    for (int i = 0; i < used_n; i++) begin
      if (i == 0 || knot_xs[i] < span_lo) span_lo = knot_xs[i];
      if (i == 0 || knot_xs[i] > span_hi) span_hi = knot_xs[i];
    end
  endtask

  // Insert random idle cycles, then hold start until the transfer happens
  task automatic send_query(logic signed [XY_W-1:0] x);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_query_x <= x;
    @(posedge clk iff !busy);
  endtask

  // Drop start and wait for every outstanding result before touching registers
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_y.size() != 0) @(posedge clk);
  endtask

  // Build a random curve: sorted full range, raw noise, extremes, or clustered
  task automatic random_curve(int kind);
    int xs[$];
    int ys[PT_SLOTS];
    int base;
    int xv;
    logic [CNT_W-1:0] cnt;
    logic [CFG_DATA_W-1:0] w[PT_SLOTS];
    if (kind == 1 || $urandom_range(99) < 10)
      cnt = CNT_W'($urandom_range(7));
    else
      cnt = CNT_W'($urandom_range(MAX_POINTS, 2));
    base = $urandom_range(65535) - 32768;
    for (int i = 0; i < PT_SLOTS; i++) begin
      case (kind)
        2: begin
          xs.push_back($urandom_range(2) == 0 ? -32768 :
                       ($urandom_range(1) ? 32767 : $urandom_range(65535) - 32768));
          ys[i] = $urandom_range(1) ? 32767 : -32768;
        end
        3: begin
          xv = base + int'($urandom_range(20));
          xs.push_back((xv > 32767) ? 32767 : xv);
          ys[i] = $urandom_range(65535) - 32768;
        end
        default: begin
          xs.push_back($urandom_range(65535) - 32768);
          ys[i] = $urandom_range(65535) - 32768;
        end
      endcase
    end
    // Keep most curves well formed so queries land on real segments
    if (kind != 1) xs.sort();
    for (int i = 0; i < PT_SLOTS; i++) w[i] = knot_word(xs[i], ys[i]);
    if (kind == 1) foreach (w[i]) w[i] = $urandom;
    load_curve(cnt, w[0], w[1], w[2], w[3], $urandom_range(3) == 0);
  endtask

  // Mostly queries inside the curve's span, some on or beside a breakpoint
  function automatic logic signed [XY_W-1:0] pick_query();
    int r;
    int k;
    r = $urandom_range(99);
    if (used_n > 0 && r < 60)
      return XY_W'(span_lo + int'($urandom_range(span_hi - span_lo)));
    if (used_n > 0 && r < 75) begin
      k = knot_xs[$urandom_range(used_n - 1)] + $urandom_range(2) - 1;
      return XY_W'(k);
    end
    return XY_W'($urandom);
  endfunction

  initial begin
    int kind;
    int r;
    sb = new();
    idle_pct = IDLE_PCT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No breakpoints after reset: everything maps to zero
    send_query(-16'sd32768);
    send_query(16'sd32767);
    drain;

    // Full-swing curve with a steep interior segment and extreme slopes
    load_curve(3'd4, knot_word(-32768, 32767), knot_word(-100, -32768),
               knot_word(100, 32767), knot_word(32767, -32768), 1'b0);
    cfg_write(REG_SPARE_FIRST, '1);
    cfg_write(CFG_IDX_W'(int'(REG_SPARE_FIRST) + 1), '1);
    cfg_write(CFG_IDX_W'(int'(REG_SPARE_FIRST) + 2), '1);
    cfg_we <= 1'b0;
    foreach (r_list[i]) send_query(r_list[i]);
    drain;

    // Count above the limit behaves as the limit
    cfg_write(REG_POINT_COUNT, 32'd7);
    cfg_we <= 1'b0;
    send_query(16'sd32767);
    send_query(16'sd200);
    drain;

    // Single breakpoint: clamp on both sides
    load_curve(3'd1, knot_word(5, -7), '0, '0, '0, 1'b0);
    send_query(16'sd4);
    send_query(16'sd5);
    send_query(16'sd6);
    drain;

    // Repeated x values and out-of-order breakpoints
    load_curve(3'd4, knot_word(0, 10), knot_word(0, -10), knot_word(50, 300),
               knot_word(50, -300), 1'b0);
    send_query(16'sd0);
    send_query(16'sd25);
    drain;
    load_curve(3'd4, knot_word(100, 1), knot_word(-100, 2), knot_word(300, 3),
               knot_word(200, 4), 1'b0);
    send_query(16'sd150);
    send_query(16'sd250);
    drain;

    // Random phases; one of them runs with no idle cycles at all
    for (int p = 0; p < 13; p++) begin
      r = $urandom_range(99);
      if (p == 0) kind = 2;
      else if (p == 1) kind = 1;
      else kind = (r < 50) ? 0 : (r < 70) ? 3 : (r < 85) ? 2 : 1;
      random_curve(kind);
      idle_pct = (p == 4) ? 0 : IDLE_PCT;
      repeat (100) send_query(pick_query());
      drain;
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_y.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
